/* rtl/fire_effect_cell_step_unit_defines.svh */
// Assertion macros for the fire effect cell step unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FIRE_EFFECT_CELL_STEP_UNIT_DEFINES_SVH
`define FIRE_EFFECT_CELL_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FECS_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fire effect check failed");
`define FECS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fire effect check failed");
`else
`define FECS_ASSERT_SAME(label, clk, rst, pre, post)
`define FECS_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* rtl/fecs_pkg.sv */
// Shared types, constants and the palette function of the fire effect cell step unit.
// No dependencies.
`default_nettype none

package fecs_pkg;

  localparam int HEAT_W = 8;
  localparam int COL_W = 3;
  localparam int ROW_W = 4;
  localparam int DEF_GRID_WIDTH = 6;
  localparam int DEF_GRID_HEIGHT = 12;

  localparam logic [HEAT_W-1:0] PAL_KNEE_RED = 8'd85;
  localparam logic [HEAT_W-1:0] PAL_KNEE_GREEN = 8'd170;
  localparam logic [HEAT_W-1:0] PAL_FULL = 8'd255;

  typedef logic [HEAT_W-1:0] heat_t;

  typedef struct packed {
    logic base;
    logic first_col;
    logic last_col;
    logic near_base;
  } cell_ctrl_t;

  typedef struct packed {
    heat_t below;
    heat_t left;
    heat_t right;
    heat_t below2;
  } nbr_t;

  typedef struct packed {
    heat_t red;
    heat_t green;
    heat_t blue;
  } rgb_t;

  function automatic heat_t times3(input heat_t v);
    logic [HEAT_W+1:0] p;
    p = {1'b0, v, 1'b0} + {2'b00, v};
    return p[HEAT_W-1:0];
  endfunction

  function automatic rgb_t palette(input heat_t h);
    rgb_t c;
    if (h < PAL_KNEE_RED) begin
      c.red = times3(h);
      c.green = '0;
      c.blue = '0;
    end else if (h < PAL_KNEE_GREEN) begin
      c.red = PAL_FULL;
      c.green = times3(h - PAL_KNEE_RED);
      c.blue = '0;
    end else begin
      c.red = PAL_FULL;
      c.green = PAL_FULL;
      c.blue = times3(h - PAL_KNEE_GREEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/fecs_ember_if.sv */
// Input channel of the fire effect cell step unit: ember heat and cooling draw.
// Depends on fecs_pkg.
`default_nettype none

interface fecs_ember_if;
  logic valid;
  logic ready;
  fecs_pkg::heat_t ember_heat;
  fecs_pkg::heat_t cooling_draw;

  modport source (output valid, output ember_heat, output cooling_draw, input ready);
  modport sink (input valid, input ember_heat, input cooling_draw, output ready);
endinterface

`default_nettype wire

/* rtl/fecs_pixel_if.sv */
// Output channel of the fire effect cell step unit: cell coordinates, heat and color.
// Depends on fecs_pkg.
`default_nettype none

interface fecs_pixel_if;
  logic valid;
  logic ready;
  logic [fecs_pkg::COL_W-1:0] column;
  logic [fecs_pkg::ROW_W-1:0] row;
  fecs_pkg::heat_t heat_value;
  fecs_pkg::heat_t red;
  fecs_pkg::heat_t green;
  fecs_pkg::heat_t blue;
  logic frame_done;

  modport source (output valid, output column, output row, output heat_value,
                  output red, output green, output blue, output frame_done,
                  input ready);
  modport sink (input valid, input column, input row, input heat_value,
                input red, input green, input blue, input frame_done,
                output ready);
endinterface

`default_nettype wire

/* rtl/fecs_heat_grid.sv */
// Heat grid held as a rotating shift line in visit order, with fixed neighbour taps.
// Depends on fecs_pkg.
`default_nettype none

module fecs_heat_grid #(
  parameter int GRID_WIDTH = fecs_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = fecs_pkg::DEF_GRID_HEIGHT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire fecs_pkg::heat_t     new_heat,
  input  wire fecs_pkg::cell_ctrl_t ctrl,
  output fecs_pkg::nbr_t           nbr
);

  // The head of the line is the cell being visited; the line rotates by one
  // cell per transaction, so each neighbour sits a fixed distance ahead.
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int TAP_BELOW = GRID_WIDTH;
  localparam int TAP_LEFT = GRID_WIDTH - 1;
  localparam int TAP_LEFT_WRAP = 2 * GRID_WIDTH - 1;
  localparam int TAP_RIGHT = GRID_WIDTH + 1;
  localparam int TAP_RIGHT_WRAP = 1;
  localparam int TAP_BELOW2 = 2 * GRID_WIDTH;

  fecs_pkg::heat_t cells [CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cells[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < CELLS - 1; i++) begin
        cells[i] <= cells[i + 1];
      end
      cells[CELLS - 1] <= new_heat;
    end
  end

  always_comb begin
    nbr.below = cells[TAP_BELOW];
    nbr.left = ctrl.first_col ? cells[TAP_LEFT_WRAP] : cells[TAP_LEFT];
    nbr.right = ctrl.last_col ? cells[TAP_RIGHT_WRAP] : cells[TAP_RIGHT];
    nbr.below2 = ctrl.near_base ? cells[TAP_BELOW] : cells[TAP_BELOW2];
  end

endmodule

`default_nettype wire

/* rtl/fecs_cell_calc.sv */
// New heat of one cell (ember or cooled neighbour average) and its palette colour.
// Depends on fecs_pkg.
`default_nettype none

module fecs_cell_calc (
  input  wire fecs_pkg::cell_ctrl_t ctrl,
  input  wire fecs_pkg::nbr_t       nbr,
  input  wire fecs_pkg::heat_t      ember_heat,
  input  wire fecs_pkg::heat_t      cooling_draw,
  output fecs_pkg::heat_t           heat,
  output fecs_pkg::rgb_t            color
);

  logic [fecs_pkg::HEAT_W+1:0] sum;
  fecs_pkg::heat_t avg;

  always_comb begin
    sum = {2'b00, nbr.below} + {2'b00, nbr.left} + {2'b00, nbr.right}
          + {2'b00, nbr.below2};
    avg = sum[fecs_pkg::HEAT_W+1:2];
    if (ctrl.base) begin
      heat = ember_heat;
    end else if (avg > cooling_draw) begin
      heat = avg - cooling_draw;
    end else begin
      heat = '0;
    end
    color = fecs_pkg::palette(heat);
  end

endmodule

`default_nettype wire

/* rtl/fire_effect_cell_step_unit.sv */
// Top level of the fire effect cell step unit: visit cursor, heat grid, cell
// calculation and result register. Depends on fecs_pkg, both channel interfaces,
// fecs_heat_grid, fecs_cell_calc and the assertion macro header.
//
//   channel | direction | payload
//   embers  | in        | ember_heat, cooling_draw
//   pixels  | out       | column, row, heat_value, red, green, blue, frame_done
//
// Each transaction on embers updates one cell in the same cycle and loads the
// result register, so one item can be taken every clock cycle while pixels is not stalled.
// The result is registered and appears on pixels in the cycle after its transaction.
// Reset clears the heat grid and starts the next frame at the base row.
// A stalled result register holds embers off only until it is taken.
`default_nettype none
`include "fire_effect_cell_step_unit_defines.svh"

module fire_effect_cell_step_unit #(
  parameter int GRID_WIDTH = fecs_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = fecs_pkg::DEF_GRID_HEIGHT
) (
  input wire logic clk,
  input wire logic rst,
  fecs_ember_if.sink embers,
  fecs_pixel_if.source pixels
);

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);

  logic [CW-1:0] cursor_column;
  logic [CW-1:0] cursor_column_next;
  logic [RW-1:0] cursor_row;
  logic [RW-1:0] cursor_row_next;
  logic base_phase;
  logic base_phase_next;
  logic frame_last;

  logic accept;
  logic out_valid;
  logic [fecs_pkg::COL_W-1:0] column;
  logic [fecs_pkg::ROW_W-1:0] row;
  fecs_pkg::heat_t heat_value;
  fecs_pkg::rgb_t color;
  logic frame_done;

  fecs_pkg::cell_ctrl_t ctrl;
  fecs_pkg::nbr_t nbr;
  fecs_pkg::heat_t new_heat;
  fecs_pkg::rgb_t new_color;
  logic [RW-1:0] row_sel;
  logic [31:0] column_wide;
  logic [31:0] row_wide;

  assign accept = embers.valid && embers.ready;
  assign embers.ready = !out_valid || pixels.ready;

  always_comb begin
    ctrl.base = base_phase;
    ctrl.first_col = (cursor_column == '0);
    ctrl.last_col = (cursor_column == CW'(GRID_WIDTH - 1));
    ctrl.near_base = (cursor_row == RW'(GRID_HEIGHT - 2));
  end

  fecs_heat_grid #(
    .GRID_WIDTH(GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_grid (
    .clk(clk),
    .rst(rst),
    .advance(accept),
    .new_heat(new_heat),
    .ctrl(ctrl),
    .nbr(nbr)
  );

  fecs_cell_calc u_calc (
    .ctrl(ctrl),
    .nbr(nbr),
    .ember_heat(embers.ember_heat),
    .cooling_draw(embers.cooling_draw),
    .heat(new_heat),
    .color(new_color)
  );

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next = cursor_row;
    base_phase_next = base_phase;
    frame_last = 1'b0;
    if (ctrl.last_col) begin
      cursor_column_next = '0;
      if (base_phase) begin
        cursor_row_next = '0;
        base_phase_next = 1'b0;
      end else if (ctrl.near_base) begin
        cursor_row_next = '0;
        base_phase_next = 1'b1;
        frame_last = 1'b1;
      end else begin
        cursor_row_next = cursor_row + RW'(1);
      end
    end else begin
      cursor_column_next = cursor_column + CW'(1);
    end
  end

  always_comb begin
    row_sel = base_phase ? RW'(GRID_HEIGHT - 1) : cursor_row;
    column_wide = 32'(cursor_column);
    row_wide = 32'(row_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row <= '0;
      base_phase <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cursor_column <= cursor_column_next;
        cursor_row <= cursor_row_next;
        base_phase <= base_phase_next;
        out_valid <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      column <= column_wide[fecs_pkg::COL_W-1:0];
      row <= row_wide[fecs_pkg::ROW_W-1:0];
      heat_value <= new_heat;
      color <= new_color;
      frame_done <= frame_last;
    end
  end

  assign pixels.valid = out_valid;
  assign pixels.column = column;
  assign pixels.row = row;
  assign pixels.heat_value = heat_value;
  assign pixels.red = color.red;
  assign pixels.green = color.green;
  assign pixels.blue = color.blue;
  assign pixels.frame_done = frame_done;

  `FECS_ASSERT_NEXT(a_frame_wrap, clk, rst, accept && frame_last, base_phase && cursor_column == '0)
  `FECS_ASSERT_NEXT(a_base_ember, clk, rst, accept && base_phase, heat_value == $past(embers.ember_heat))
  `FECS_ASSERT_NEXT(a_full_cool, clk, rst, accept && !base_phase && embers.cooling_draw == 8'hFF, heat_value == '0)
  `FECS_ASSERT_SAME(a_row_range, clk, rst, !base_phase, cursor_row <= RW'(GRID_HEIGHT - 2))

endmodule

`default_nettype wire
